@@ rtl/core/kreg_pkg.sv @@
// Shared constants and types for the key registry resolve and insert unit.
package kreg_pkg;

   localparam int TableEntries = 64;
   localparam int KeyBytes     = 16;
   localparam int SlotW        = $clog2(TableEntries);
   localparam int CountW       = $clog2(TableEntries + 1);
   localparam int KeyIdxW      = $clog2(KeyBytes);
   localparam int LenW         = $clog2(KeyBytes + 1);
   localparam int MemDepth     = TableEntries * KeyBytes;
   localparam int MemAddrW     = $clog2(MemDepth);

   localparam logic [7:0] OWN_NAMESPACE = 8'd2;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;

   localparam logic [1:0] ACT_KEY   = 2'd0;
   localparam logic [1:0] ACT_CHECK = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_VERSION = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_DENIED  = 3'd4;
   localparam logic [2:0] ST_FULL    = 3'd5;

   localparam logic CSR_VERSION = 1'b0;
   localparam logic CSR_LIMIT   = 1'b1;

   typedef struct packed {
      logic              clear_table;
      logic              clear_key;
      logic              take_byte;
      logic              slot_load;
      logic              slot_reset;
      logic              byte_reset;
      logic              byte_advance;
      logic              cmp_clear;
      logic              insert_write;
      logic              insert_commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              key_bad;
      logic              slots_done;
      logic              slot_len_ok;
      logic              byte_done;
      logic              byte_mismatch;
      logic              table_full;
      logic              copy_done;
   } ctrl_status_type;

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

@@ rtl/core/kreg_datapath.sv @@
// Key buffer, stored key memory, slot and byte counters for the key registry.
module kreg_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  kreg_pkg::ctrl_cmd_type cmd,
   output kreg_pkg::ctrl_status_type stat,
   input  logic [7:0]             key_byte,
   input  logic [6:0]             entry_limit,
   output logic [kreg_pkg::CountW-1:0] entry_total,
   output logic [kreg_pkg::SlotW-1:0]  slot_index
);
   import kreg_pkg::*;

   logic [7:0]         in_key_ff [KeyBytes];
   logic [LenW-1:0]    in_len_ff, in_len_in;
   logic               overlong_ff, overlong_in;
   logic [CountW-1:0]  total_ff, total_in;
   logic [7:0]         key_mem [MemDepth];
   logic [LenW-1:0]    len_mem [TableEntries];
   logic [CountW-1:0]  slot_ff;
   logic [LenW-1:0]    byte_ff;
   logic [7:0]         mem_rd_ff;
   logic [LenW-1:0]    len_rd_ff;
   logic               mismatch_ff;
   logic [MemAddrW-1:0] rd_addr;
   logic [MemAddrW-1:0] wr_addr;

   assign rd_addr = {slot_ff[SlotW-1:0], byte_ff[KeyIdxW-1:0]};
   assign wr_addr = {total_ff[SlotW-1:0], byte_ff[KeyIdxW-1:0]};

   always_comb begin
      in_len_in   = in_len_ff;
      overlong_in = overlong_ff;
      if (cmd.clear_key) begin
         in_len_in   = '0;
         overlong_in = 1'b0;
      end else if (cmd.take_byte) begin
         if (in_len_ff < LenW'(KeyBytes - 1)) begin
            in_len_in = in_len_ff + 1'b1;
         end else begin
            overlong_in = 1'b1;
         end
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.clear_table) begin
         total_in = '0;
      end else if (cmd.insert_commit) begin
         total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_len_ff   <= '0;
         overlong_ff <= 1'b0;
         total_ff    <= '0;
      end else begin
         in_len_ff   <= in_len_in;
         overlong_ff <= overlong_in;
         total_ff    <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_byte && !cmd.clear_key && in_len_ff < LenW'(KeyBytes - 1)) begin
         in_key_ff[in_len_ff[KeyIdxW-1:0]] <= fold_lower(key_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_reset) begin
         slot_ff <= '0;
      end else if (cmd.slot_load) begin
         slot_ff <= slot_ff + 1'b1;
      end
      if (cmd.byte_reset) begin
         byte_ff <= '0;
      end else if (cmd.byte_advance) begin
         byte_ff <= byte_ff + 1'b1;
      end
      if (cmd.cmp_clear) begin
         mismatch_ff <= 1'b0;
      end else if (cmd.byte_advance && !cmd.insert_write &&
                   mem_rd_ff != in_key_ff[byte_ff[KeyIdxW-1:0]]) begin
         mismatch_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert_write) begin
         key_mem[wr_addr] <= in_key_ff[byte_ff[KeyIdxW-1:0]];
      end
      mem_rd_ff <= key_mem[cmd.byte_advance ? MemAddrW'(rd_addr + 1'b1) : rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.insert_commit) begin
         len_mem[total_ff[SlotW-1:0]] <= in_len_ff;
      end
      len_rd_ff <= len_mem[slot_ff[SlotW-1:0]];
   end

   assign stat.key_bad       = overlong_ff || in_len_ff == '0;
   assign stat.slots_done    = slot_ff >= total_ff;
   assign stat.slot_len_ok   = len_rd_ff == in_len_ff;
   assign stat.byte_done     = byte_ff >= in_len_ff;
   assign stat.byte_mismatch = mismatch_ff;
   assign stat.table_full    = total_ff >= CountW'(entry_limit) ||
                               total_ff >= CountW'(TableEntries);
   assign stat.copy_done     = byte_ff >= in_len_ff;
   assign entry_total        = total_ff;
   assign slot_index         = slot_ff[SlotW-1:0];

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CountW'(TableEntries)) else $error("entry total beyond table");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      in_len_ff <= LenW'(KeyBytes - 1)) else $error("key length beyond buffer");
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert_commit |-> !stat.table_full) else $error("insert into full table");
`endif
endmodule

@@ rtl/core/kreg_control.sv @@
// Sequencer for key search, insert, handle check and clear.
module kreg_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic                      req_key_last,
   input  logic                      req_confirm,
   input  logic [31:0]               req_query_handle,
   input  logic [7:0]                table_version,
   input  kreg_pkg::ctrl_status_type stat,
   input  logic [kreg_pkg::CountW-1:0] entry_total,
   input  logic [kreg_pkg::SlotW-1:0]  slot_index,
   output kreg_pkg::ctrl_cmd_type    cmd,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic [31:0]               rsp_result_handle,
   output logic [6:0]                rsp_entries_held
);
   import kreg_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_LEN    = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_COPY   = 3'd4;
   localparam logic [2:0] S_FIRST  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic        confirm_ff, confirm_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] handle_ff, handle_in;
   logic [6:0]  held_ff, held_in;
   logic [15:0] q_slot;
   logic        accept;

   assign accept = start && !busy;
   assign busy   = state_ff != S_IDLE;
   assign q_slot = req_query_handle[15:0];

   function automatic logic [31:0] make_handle(input logic [7:0] ver,
                                                input logic [15:0] slot);
      return {OWN_NAMESPACE, ver, slot};
   endfunction

   always_comb begin
      state_in     = state_ff;
      confirm_in   = confirm_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      handle_in    = handle_ff;
      held_in      = held_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_KEY: begin
                     cmd.take_byte = 1'b1;
                     confirm_in    = req_confirm;
                     if (req_key_last) begin
                        cmd.slot_reset = 1'b1;
                        cmd.byte_reset = 1'b1;
                        state_in       = S_FIRST;
                     end
                  end
                  ACT_CHECK: begin
                     rsp_valid_in = 1'b1;
                     handle_in    = '0;
                     held_in      = 7'(entry_total);
                     if (req_query_handle[31:24] != OWN_NAMESPACE) begin
                        status_in = ST_INVALID;
                     end else if (req_query_handle[23:16] != table_version) begin
                        status_in = ST_VERSION;
                     end else if (q_slot == '0 || q_slot > 16'(entry_total)) begin
                        status_in = ST_UNKNOWN;
                     end else begin
                        status_in = ST_OK;
                     end
                  end
                  ACT_CLEAR: begin
                     cmd.clear_table = 1'b1;
                     cmd.clear_key   = 1'b1;
                     rsp_valid_in    = 1'b1;
                     status_in       = ST_OK;
                     handle_in       = '0;
                     held_in         = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIRST: begin
            if (stat.key_bad) begin
               rsp_valid_in  = 1'b1;
               status_in     = ST_INVALID;
               handle_in     = '0;
               held_in       = 7'(entry_total);
               cmd.clear_key = 1'b1;
               state_in      = S_IDLE;
            end else if (stat.slots_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.cmp_clear = 1'b1;
               state_in      = S_LEN;
            end
         end
         S_LEN: begin
            if (stat.slot_len_ok) begin
               state_in = S_CMP;
            end else begin
               cmd.slot_load  = 1'b1;
               cmd.byte_reset = 1'b1;
               state_in       = S_FIRST;
            end
         end
         S_CMP: begin
            if (stat.byte_done) begin
               if (!stat.byte_mismatch) begin
                  rsp_valid_in  = 1'b1;
                  status_in     = ST_OK;
                  handle_in     = make_handle(table_version, 16'(slot_index) + 16'd1);
                  held_in       = 7'(entry_total);
                  cmd.clear_key = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.slot_load  = 1'b1;
                  cmd.byte_reset = 1'b1;
                  state_in       = S_FIRST;
               end
            end else begin
               cmd.byte_advance = 1'b1;
            end
         end
         S_DECIDE: begin
            if (!confirm_ff || stat.table_full) begin
               rsp_valid_in  = 1'b1;
               status_in     = confirm_ff ? ST_FULL : ST_DENIED;
               handle_in     = '0;
               held_in       = 7'(entry_total);
               cmd.clear_key = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.byte_reset = 1'b1;
               state_in       = S_COPY;
            end
         end
         S_COPY: begin
            if (stat.copy_done) begin
               cmd.insert_commit = 1'b1;
               cmd.clear_key     = 1'b1;
               rsp_valid_in      = 1'b1;
               status_in         = ST_OK;
               handle_in         = make_handle(table_version, 16'(entry_total) + 16'd1);
               held_in           = 7'(entry_total + 1'b1);
               state_in          = S_IDLE;
            end else begin
               cmd.insert_write = 1'b1;
               cmd.byte_advance = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      confirm_ff <= confirm_in;
      status_ff  <= status_in;
      handle_ff  <= handle_in;
      held_ff    <= held_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_handle = handle_ff;
   assign rsp_entries_held  = held_ff;

`ifndef SYNTHESIS
   a_busy_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_KEY && !req_key_last) |=> !rsp_valid)
      else $error("result on inner key byte");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_IDLE) else $error("result while searching");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_result_handle == '0)
      else $error("handle on failed result");
`endif
endmodule

@@ rtl/core/key_registry_resolve_insert_unit.sv @@
// Top level of the key registry resolve and insert unit.
// Items are taken when start is high and busy low. Key bytes that are not last,
// handle checks and clears leave busy low, and a check or clear answers on the
// next cycle. A final key byte starts a search over the stored slots through a
// one-byte-wide key memory port: a slot is compared byte by byte only if its
// stored length matches; on a miss a confirmed key is copied byte by byte into
// the table if it has room. An overlong or empty key is answered as invalid
// before any slot is searched. The result is registered and follows in the
// cycle after the search ends. rsp_valid marks each result for one cycle; the
// receiver cannot stall it. Configuration writes are always ready.
module key_registry_resolve_insert_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_key_byte,
   input  logic        req_key_last,
   input  logic        req_confirm,
   input  logic [31:0] req_query_handle,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_result_handle,
   output logic [6:0]  rsp_entries_held,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import kreg_pkg::*;

   ctrl_cmd_type        cmd;
   ctrl_status_type     stat;
   logic [7:0]          version_ff;
   logic [6:0]          limit_ff;
   logic [CountW-1:0]   entry_total;
   logic [SlotW-1:0]    slot_index;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'd1;
         limit_ff   <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VERSION: version_ff <= csr_data;
            CSR_LIMIT:   limit_ff   <= csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   kreg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .key_byte    (req_key_byte),
      .entry_limit (limit_ff),
      .entry_total (entry_total),
      .slot_index  (slot_index)
   );

   kreg_control u_control (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_key_last      (req_key_last),
      .req_confirm       (req_confirm),
      .req_query_handle  (req_query_handle),
      .table_version     (version_ff),
      .stat              (stat),
      .entry_total       (entry_total),
      .slot_index        (slot_index),
      .cmd               (cmd),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_result_handle (rsp_result_handle),
      .rsp_entries_held  (rsp_entries_held)
   );
endmodule
